// File: rtl/text_console_teletype_defines.svh
// ---------------------------------------------------------------------------
// text console teletype assertion macros
// shared checks used by the console rtl
// ---------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_TELETYPE_DEFINES_SVH
`define TEXT_CONSOLE_TELETYPE_DEFINES_SVH

// expression holds at every clock edge out of reset
`define TTC_ASSERT_ALWAYS(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("ttc check failed");

// consequent holds in the cycle after the antecedent
`define TTC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ttc sequence check failed");

`endif

// File: rtl/ttc_pkg.sv
// ---------------------------------------------------------------------------
// ttc_pkg
// types, constants and control codes of the text console teletype
// ---------------------------------------------------------------------------
package ttc_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int ADDR_W  = $clog2(CELLS);

   localparam int OP_W    = 2;
   localparam int CHAR_W  = 8;
   localparam int IDX_W   = 11;
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int VALUE_W = 16;
   localparam int ATTR_W  = 8;

   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;

   localparam logic [VALUE_W-1:0] BLANK_CELL = 16'h0700;
   localparam logic [ATTR_W-1:0]  ATTR_RESET = 8'h07;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [CHAR_W-1:0] char_code;
      logic [IDX_W-1:0]  cell_index;
   } ttc_req_type;

   typedef struct packed {
      logic               serial_valid;
      logic [CHAR_W-1:0]  serial_byte;
      logic [COL_W-1:0]   cursor_col;
      logic [ROW_W-1:0]   cursor_row;
      logic [VALUE_W-1:0] cell_value;
   } ttc_rsp_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_PUT,
      ST_READ,
      ST_COPY,
      ST_TAIL,
      ST_CLEAR,
      ST_DONE
   } ttc_state_type;

   typedef struct packed {
      logic accept;
      logic home;
      logic put_step;
      logic read_step;
      logic copy_step;
      logic blank_step;
      logic cnt_clear;
      logic cnt_inc;
      logic load_rsp;
   } ttc_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] req_op;
      logic            scroll;
      logic            copy_last;
      logic            blank_last;
      logic            out_free;
   } ttc_status_type;

endpackage

// File: rtl/ttc_ctrl.sv
// ---------------------------------------------------------------------------
// ttc_ctrl
// sequencer for put, read, clear, scroll and the clearing sweep after reset
// ---------------------------------------------------------------------------
module ttc_ctrl
   import ttc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  ttc_status_type status,
   output ttc_cmd_type    cmd
);

   ttc_state_type state_ff;
   ttc_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (status.blank_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (status.req_op)
                  OP_PUT:   state_in = ST_PUT;
                  OP_READ:  state_in = ST_READ;
                  OP_CLEAR: state_in = ST_CLEAR;
                  default:  state_in = ST_DONE;
               endcase
            end
         end
         ST_PUT: begin
            state_in = status.scroll ? ST_COPY : ST_DONE;
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_COPY: begin
            if (status.copy_last) state_in = ST_TAIL;
         end
         ST_TAIL, ST_CLEAR: begin
            if (status.blank_last) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_INIT: begin
            cmd.blank_step = 1'b1;
            cmd.cnt_inc    = 1'b1;
         end
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
            if (req_valid && (status.req_op == OP_CLEAR)) begin
               cmd.home      = 1'b1;
               cmd.cnt_clear = 1'b1;
            end
         end
         ST_PUT: begin
            cmd.put_step  = 1'b1;
            cmd.cnt_clear = 1'b1;
         end
         ST_READ: begin
            cmd.read_step = 1'b1;
         end
         ST_COPY: begin
            cmd.copy_step = 1'b1;
            cmd.cnt_inc   = 1'b1;
         end
         ST_TAIL, ST_CLEAR: begin
            cmd.blank_step = 1'b1;
            cmd.cnt_inc    = 1'b1;
         end
         ST_DONE: begin
            cmd.load_rsp = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: rtl/ttc_dpath.sv
// ---------------------------------------------------------------------------
// ttc_dpath
// screen store, cursor, sweep counter, attribute register and result register
// ---------------------------------------------------------------------------
`include "text_console_teletype_defines.svh"

module ttc_dpath
   import ttc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  ttc_req_type       req_data,
   input  logic              csr_valid,
   input  logic [ATTR_W-1:0] csr_data,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output ttc_rsp_type       rsp_data,
   input  ttc_cmd_type       cmd,
   output ttc_status_type    status
);

   logic [VALUE_W-1:0] mem_ff [CELLS];
   logic [VALUE_W-1:0] rd_data_ff;
   logic               wr_en_ff;
   logic               wr_copy_ff;
   logic [ADDR_W-1:0]  wr_addr_ff;
   logic [ADDR_W-1:0]  cnt_ff;
   logic [COL_W-1:0]   cur_col_ff;
   logic [ROW_W-1:0]   cur_line_ff;
   logic [ATTR_W-1:0]  attr_ff;
   ttc_req_type        req_ff;
   logic               rsp_valid_ff;
   ttc_rsp_type        rsp_data_ff;

   logic [COL_W:0]     col_next;
   logic [ROW_W:0]     line_next;
   logic [ROW_W-1:0]   line_final;
   logic               printable;
   logic               put_we;
   logic               scroll;
   logic [ADDR_W-1:0]  pos;
   logic [ADDR_W-1:0]  rd_addr;
   logic               rd_en;
   logic               idx_ok;
   logic               out_free;
   logic               cursor_ok;

   // next cursor of a put
   always_comb begin
      col_next  = {1'b0, cur_col_ff};
      line_next = {1'b0, cur_line_ff};
      printable = 1'b0;
      case (req_ff.char_code)
         CH_NEWLINE: begin
            col_next  = '0;
            line_next = line_next + 1'b1;
         end
         CH_RETURN: begin
            col_next = '0;
         end
         CH_BACKSPACE: begin
            if (cur_col_ff != '0) col_next = col_next - 1'b1;
         end
         default: begin
            printable = 1'b1;
            col_next  = col_next + 1'b1;
         end
      endcase
      if (32'(col_next) >= 32'(COLUMNS)) begin
         col_next  = '0;
         line_next = line_next + 1'b1;
      end
      scroll     = 32'(line_next) >= 32'(ROWS);
      line_final = scroll ? ROW_W'(ROWS - 1) : line_next[ROW_W-1:0];
   end

   assign pos     = ADDR_W'(32'(cur_line_ff) * COLUMNS + 32'(cur_col_ff));
   assign put_we  = cmd.put_step && printable;
   assign idx_ok  = 32'(req_ff.cell_index) < 32'(CELLS);
   assign rd_addr = cmd.copy_step ? ADDR_W'(32'(cnt_ff) + COLUMNS)
                                  : ADDR_W'(req_ff.cell_index);
   assign rd_en   = cmd.copy_step || (cmd.read_step && idx_ok);

   // store with one write and one read port
   always_ff @(posedge clock) begin
      if (put_we) begin
         mem_ff[pos] <= {attr_ff, req_ff.char_code};
      end else if (wr_en_ff) begin
         mem_ff[wr_addr_ff] <= wr_copy_ff ? rd_data_ff : BLANK_CELL;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // delayed write stage for copy and blank sweeps
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_en_ff <= 1'b0;
      end else begin
         wr_en_ff <= cmd.copy_step || cmd.blank_step;
      end
      wr_copy_ff <= cmd.copy_step;
      wr_addr_ff <= cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_clear) begin
         cnt_ff <= '0;
      end else if (cmd.cnt_inc) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_col_ff  <= '0;
         cur_line_ff <= '0;
      end else if (cmd.home) begin
         cur_col_ff  <= '0;
         cur_line_ff <= '0;
      end else if (cmd.put_step) begin
         cur_col_ff  <= col_next[COL_W-1:0];
         cur_line_ff <= line_final;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
      end else if (csr_valid) begin
         attr_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_data;
      end
   end

   // result register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_data_ff.serial_valid <= req_ff.op == OP_PUT;
         rsp_data_ff.serial_byte  <= (req_ff.op == OP_PUT) ? req_ff.char_code : '0;
         rsp_data_ff.cursor_col   <= cur_col_ff;
         rsp_data_ff.cursor_row   <= cur_line_ff;
         rsp_data_ff.cell_value   <= ((req_ff.op == OP_READ) && idx_ok) ? rd_data_ff : '0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign status.req_op     = req_data.op;
   assign status.scroll     = scroll;
   assign status.copy_last  = cnt_ff == ADDR_W'(CELLS - COLUMNS - 1);
   assign status.blank_last = cnt_ff == ADDR_W'(CELLS - 1);
   assign status.out_free   = out_free;

   assign cursor_ok = (32'(cur_col_ff) < 32'(COLUMNS)) && (32'(cur_line_ff) < 32'(ROWS));

   `TTC_ASSERT_ALWAYS(a_single_write, clock, reset, !(put_we && wr_en_ff))
   `TTC_ASSERT_ALWAYS(a_cursor_range, clock, reset, cursor_ok)
   `TTC_ASSERT_NEXT(a_copy_writes_back, clock, reset, cmd.copy_step, wr_en_ff && wr_copy_ff)

endmodule

// File: rtl/text_console_teletype.sv
// ---------------------------------------------------------------------------
// text_console_teletype: 80x25 text console with cursor and serial echo
// put, read, unused op: one transfer at a time, next transfer taken after the result is loaded
// scroll put: 1920 cell copy, then 80 cell blank of the last row, before the result
// clear: 2000 cell blank sweep before the result; reset: 2000 cell blank sweep, req stalled
// ---------------------------------------------------------------------------
module text_console_teletype
   import ttc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ttc_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ttc_rsp_type       rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [ATTR_W-1:0] csr_data
);

   ttc_cmd_type    cmd;
   ttc_status_type status;

   assign csr_ready = 1'b1;

   ttc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ttc_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
